// File: rtl/lfs_pkg.sv
// Package for the line follower PD steering block: shared types, register
// indexes, reset values and the sensor pattern decoder. No dependencies.
package lfs_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned DATA_W      = 32;

  localparam logic [6:0] TURN_LIMIT_RESET = 7'd20;

  typedef enum logic [2:0] {
    REG_TURN_LIMIT = 3'd0,
    REG_FULL_SPEED = 3'd1,
    REG_TURN_SPEED = 3'd2,
    REG_PROP_GAIN  = 3'd3,
    REG_DERIV_GAIN = 3'd4,
    REG_ERR_OFFSET = 3'd5
  } reg_idx_e;

  // Classification of one sensor pattern.
  typedef enum logic [1:0] {
    KIND_HOLD  = 2'd0,
    KIND_TRACK = 2'd1,
    KIND_LEFT  = 2'd2,
    KIND_RIGHT = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic signed [4:0] track_err;
  } entry_t;

  typedef struct packed {
    logic        [6:0]  turn_limit;
    logic signed [15:0] full_speed;
    logic signed [15:0] turn_speed;
    logic signed [15:0] prop_gain;
    logic signed [15:0] deriv_gain;
    logic signed [7:0]  err_offset;
  } cfg_t;

  // Lone sensors and adjacent pairs give a tracking error; the wide left and
  // right shapes mark a right-angle turn; anything else holds the last error.
  function automatic entry_t decode_pattern(logic [7:0] p);
    entry_t e;
    e.kind      = KIND_TRACK;
    e.track_err = 5'sd0;
    case (p)
      8'h80: e.track_err = -5'sd13;
      8'hC0: e.track_err = -5'sd11;
      8'h40: e.track_err = -5'sd9;
      8'h60: e.track_err = -5'sd7;
      8'h20: e.track_err = -5'sd5;
      8'h30: e.track_err = -5'sd3;
      8'h10: e.track_err = -5'sd1;
      8'h18: e.track_err = 5'sd0;
      8'h08: e.track_err = 5'sd1;
      8'h0C: e.track_err = 5'sd3;
      8'h04: e.track_err = 5'sd5;
      8'h06: e.track_err = 5'sd7;
      8'h02: e.track_err = 5'sd9;
      8'h03: e.track_err = 5'sd11;
      8'h01: e.track_err = 5'sd13;
      8'h70, 8'hFC, 8'hF8, 8'hF0, 8'hE0: e.kind = KIND_LEFT;
      8'h07, 8'h0F, 8'h1F, 8'h3F, 8'h0E: e.kind = KIND_RIGHT;
      default: e.kind = KIND_HOLD;
    endcase
    return e;
  endfunction

endpackage

// File: rtl/lfs_front.sv
// Front end: accepts sensor transfers and classifies each pattern.
// Depends on lfs_pkg.
module lfs_front (
  input  logic            in_valid_i,
  input  logic [7:0]      sensor_bits_i,
  input  logic            queue_full_i,
  output logic            in_ready_o,
  output logic            push_o,
  output lfs_pkg::entry_t entry_o
);
  import lfs_pkg::*;

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;
  assign entry_o    = decode_pattern(sensor_bits_i);

endmodule

// File: rtl/lfs_queue.sv
// Small FIFO of classified items between the front and back ends.
// Depends on lfs_pkg.
module lfs_queue #(
  parameter int unsigned Depth = lfs_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lfs_pkg::entry_t entry_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output lfs_pkg::entry_t entry_o
);
  import lfs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count exceeds depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count did not grow on push");

endmodule

// File: rtl/lfs_back.sv
// Back end: updates the held error and speed, forms bias and its change,
// then the PD products, with an output register. Depends on lfs_pkg.
module lfs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lfs_pkg::cfg_t       cfg_i,
  input  logic                entry_valid_i,
  input  lfs_pkg::entry_t     entry_i,
  output logic                pop_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic signed [25:0]  steer_o,
  output logic signed [15:0]  speed_o,
  output logic signed [7:0]   line_error_o,
  output logic signed [8:0]   bias_o
);
  import lfs_pkg::*;

  // Loop state.
  logic signed [7:0]  held_err_q, held_err_d;
  logic signed [15:0] held_speed_q, held_speed_d;
  logic signed [8:0]  prev_bias_q;

  // Stage A: bias and its change.
  logic               a_valid_q;
  logic signed [7:0]  a_err_q;
  logic signed [15:0] a_speed_q;
  logic signed [8:0]  a_bias_q, bias_d;
  logic signed [9:0]  a_diff_q, diff_d;

  // Output stage.
  logic               o_valid_q;
  logic signed [25:0] steer_q;
  logic signed [15:0] speed_q;
  logic signed [7:0]  err_q;
  logic signed [8:0]  bias_q;

  logic               o_free, a_ready;
  logic signed [7:0]  limit_s;
  logic signed [24:0] prop_prod;
  logic signed [25:0] deriv_prod;
  logic signed [26:0] steer_sum;

  assign o_free  = !o_valid_q || out_ready_i;
  assign a_ready = !a_valid_q || o_free;
  assign pop_o   = entry_valid_i && a_ready;
  assign limit_s = $signed({1'b0, cfg_i.turn_limit});

  always_comb begin
    held_err_d   = held_err_q;
    held_speed_d = held_speed_q;
    case (entry_i.kind)
      KIND_TRACK: begin
        held_err_d   = {{3{entry_i.track_err[4]}}, entry_i.track_err};
        held_speed_d = cfg_i.full_speed;
      end
      KIND_LEFT: begin
        held_err_d   = -limit_s;
        held_speed_d = cfg_i.turn_speed;
      end
      KIND_RIGHT: begin
        held_err_d   = limit_s;
        held_speed_d = cfg_i.turn_speed;
      end
      default: begin
        held_err_d   = held_err_q;
        held_speed_d = held_speed_q;
      end
    endcase
    bias_d = {held_err_d[7], held_err_d} - {cfg_i.err_offset[7], cfg_i.err_offset};
    diff_d = {bias_d[8], bias_d} - {prev_bias_q[8], prev_bias_q};
  end

  assign prop_prod  = cfg_i.prop_gain * a_bias_q;
  assign deriv_prod = cfg_i.deriv_gain * a_diff_q;
  assign steer_sum  = {{2{prop_prod[24]}}, prop_prod} + {deriv_prod[25], deriv_prod};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_err_q   <= '0;
      held_speed_q <= '0;
      prev_bias_q  <= '0;
      a_valid_q    <= 1'b0;
      o_valid_q    <= 1'b0;
    end else begin
      if (pop_o) begin
        held_err_q   <= held_err_d;
        held_speed_q <= held_speed_d;
        prev_bias_q  <= bias_d;
      end
      if (a_ready) begin
        a_valid_q <= entry_valid_i;
      end
      if (o_free) begin
        o_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_err_q   <= held_err_d;
      a_speed_q <= held_speed_d;
      a_bias_q  <= bias_d;
      a_diff_q  <= diff_d;
    end
    if (o_free && a_valid_q) begin
      steer_q <= steer_sum[25:0];
      speed_q <= a_speed_q;
      err_q   <= a_err_q;
      bias_q  <= a_bias_q;
    end
  end

  assign out_valid_o  = o_valid_q;
  assign steer_o      = steer_q;
  assign speed_o      = speed_q;
  assign line_error_o = err_q;
  assign bias_o       = bias_q;

  a_prev_tracks_bias: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (prev_bias_q == a_bias_q))
    else $error("previous bias not updated with the issued bias");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !o_free) |=> (a_valid_q && $stable(a_bias_q) && !$past(pop_o)))
    else $error("stage A lost or overwrote a stalled item");

endmodule

// File: rtl/line_follow_steering_pd.sv
// Line follower PD steering controller, top level. Depends on lfs_pkg,
// lfs_front, lfs_queue and lfs_back.
// Throughput: one sensor transfer per cycle, sustained, when the output side is ready.
// Path: a result goes through the queue, the bias stage and the product stage in turn;
// the two-entry queue lets input and output stall independently.
// Reset (asynchronous, active low) clears the queue, the held error, speed and bias,
// and loads the register reset values (turn limit 20, all others zero).
module line_follow_steering_pd #(
  parameter int unsigned QueueDepth = lfs_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfs_pkg::ADDR_W-1:0]   paddr,
  input  logic [lfs_pkg::DATA_W-1:0]   pwdata,
  output logic [lfs_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  // Sensor input channel.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   sensor_bits_i,
  // Steering result channel.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [25:0]           steer_o,
  output logic signed [15:0]           speed_o,
  output logic signed [7:0]            line_error_o,
  output logic signed [8:0]            bias_o
);
  import lfs_pkg::*;

  // Configuration registers. A write lands on the access cycle of an APB
  // transfer; the word index comes from address bits 4:2, so index six and
  // seven are ignored on write and read back as zero.
  cfg_t       cfg_q;
  logic       cfg_wr;
  reg_idx_e   reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.turn_limit <= TURN_LIMIT_RESET;
      cfg_q.full_speed <= '0;
      cfg_q.turn_speed <= '0;
      cfg_q.prop_gain  <= '0;
      cfg_q.deriv_gain <= '0;
      cfg_q.err_offset <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TURN_LIMIT: cfg_q.turn_limit <= pwdata[6:0];
        REG_FULL_SPEED: cfg_q.full_speed <= pwdata[15:0];
        REG_TURN_SPEED: cfg_q.turn_speed <= pwdata[15:0];
        REG_PROP_GAIN:  cfg_q.prop_gain  <= pwdata[15:0];
        REG_DERIV_GAIN: cfg_q.deriv_gain <= pwdata[15:0];
        REG_ERR_OFFSET: cfg_q.err_offset <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read data is the raw register bits, zero padded to the bus width.
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_TURN_LIMIT: prdata[6:0]  = cfg_q.turn_limit;
      REG_FULL_SPEED: prdata[15:0] = cfg_q.full_speed;
      REG_TURN_SPEED: prdata[15:0] = cfg_q.turn_speed;
      REG_PROP_GAIN:  prdata[15:0] = cfg_q.prop_gain;
      REG_DERIV_GAIN: prdata[15:0] = cfg_q.deriv_gain;
      REG_ERR_OFFSET: prdata[7:0]  = cfg_q.err_offset;
      default:        prdata       = '0;
    endcase
  end

  // The front end classifies each accepted pattern and pushes it into the
  // queue in the same cycle; it is ready whenever the queue has room.
  entry_t front_entry, queue_entry;
  logic   push, pop, queue_full, queue_valid;

  lfs_front u_front (
    .in_valid_i    (in_valid_i),
    .sensor_bits_i (sensor_bits_i),
    .queue_full_i  (queue_full),
    .in_ready_o    (in_ready_o),
    .push_o        (push),
    .entry_o       (front_entry)
  );

  lfs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (pop),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .entry_o (queue_entry)
  );

  // The back end owns the loop state (held error, held speed, previous
  // bias). It updates that state as it pops an item, so the next pop already
  // sees it, and computes the two gain products in the following stage.
  lfs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .entry_valid_i (queue_valid),
    .entry_i       (queue_entry),
    .pop_o         (pop),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .steer_o       (steer_o),
    .speed_o       (speed_o),
    .line_error_o  (line_error_o),
    .bias_o        (bias_o)
  );

endmodule

// File: test/line_follow_steering_pd_test.sv
// Self-checking testbench for line_follow_steering_pd: sensor patterns in, PD steering out.
// Depends on lfs_pkg and the line_follow_steering_pd RTL; it needs no other file.
module line_follow_steering_pd_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lfs_pkg::*;

  // Results pass through the queue, the bias stage and the output register, so a short settle
  // is enough once the last expected result has been taken.
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned RANDOM_PHASES  = 6;
  localparam int unsigned PHASE_ITEMS    = 310;
  localparam int unsigned PAUSE_AT_ITEM  = 150;

  // Tracking patterns ordered from the leftmost lone sensor to the rightmost one,
  // so that a step of one index moves the line by one half sensor.
  localparam logic [7:0] TRACK_PATTERNS [15] = '{
    8'h80, 8'hC0, 8'h40, 8'h60, 8'h20, 8'h30, 8'h10, 8'h18,
    8'h08, 8'h0C, 8'h04, 8'h06, 8'h02, 8'h03, 8'h01
  };
  localparam logic [7:0] LEFT_TURNS  [5] = '{8'h70, 8'hFC, 8'hF8, 8'hF0, 8'hE0};
  localparam logic [7:0] RIGHT_TURNS [5] = '{8'h07, 8'h0F, 8'h1F, 8'h3F, 8'h0E};

  typedef enum int unsigned {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_HALF,
    READY_LONG_STALLS
  } ready_style_e;

  typedef struct packed {
    logic signed [25:0] steer;
    logic signed [15:0] speed;
    logic signed [7:0]  line_error;
    logic signed [8:0]  bias;
  } steer_result_t;

  // Every input of the block has a known value from time zero on.
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ADDR_W-1:0]   paddr         = '0;
  logic [DATA_W-1:0]   pwdata        = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [7:0]          sensor_bits_i = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic signed [25:0]  steer_o;
  logic signed [15:0]  speed_o;
  logic signed [7:0]   line_error_o;
  logic signed [8:0]   bias_o;

  line_follow_steering_pd u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sensor_bits_i(sensor_bits_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .steer_o      (steer_o),
    .speed_o      (speed_o),
    .line_error_o (line_error_o),
    .bias_o       (bias_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(3_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  // Shadow copy of the control registers, at the widths the block keeps them.
  logic        [6:0]  cfg_turn_limit = TURN_LIMIT_RESET;
  logic signed [15:0] cfg_full_speed = '0;
  logic signed [15:0] cfg_turn_speed = '0;
  logic signed [15:0] cfg_prop_gain  = '0;
  logic signed [15:0] cfg_deriv_gain = '0;
  logic signed [7:0]  cfg_err_offset = '0;

  // Shadow copy of the block's internal state; all of it clears on reset.
  logic signed [7:0]  held_error = '0;
  logic signed [15:0] held_speed = '0;
  logic signed [8:0]  last_bias  = '0;

  steer_result_t pending_results[$];
  int unsigned   mismatch_count = 0;

  // Sender pacing state. In a burst the sender never idles.
  bit          sender_burst = 1'b0;
  int unsigned sweep_pos    = 7;

  // Works out the result of one sensor transfer and advances the shadow state.
  // An unknown pattern leaves the held error and speed alone, but the bias and
  // the derivative term are still recomputed, since the offset may have changed.
  function automatic steer_result_t predict_steering(input logic [7:0] bits);
    kind_e         kind;
    int            err;
    int            bias_now;
    int            bias_delta;
    longint        drive;
    steer_result_t r;
    kind = KIND_TRACK;
    err  = 0;
    case (bits)
      8'h80: err = -13;
      8'hC0: err = -11;
      8'h40: err = -9;
      8'h60: err = -7;
      8'h20: err = -5;
      8'h30: err = -3;
      8'h10: err = -1;
      8'h18: err = 0;
      8'h08: err = 1;
      8'h0C: err = 3;
      8'h04: err = 5;
      8'h06: err = 7;
      8'h02: err = 9;
      8'h03: err = 11;
      8'h01: err = 13;
      8'h70, 8'hFC, 8'hF8, 8'hF0, 8'hE0: kind = KIND_LEFT;
      8'h07, 8'h0F, 8'h1F, 8'h3F, 8'h0E: kind = KIND_RIGHT;
      default: kind = KIND_HOLD;
    endcase
    case (kind)
      KIND_TRACK: begin
        held_error = 8'(err);
        held_speed = cfg_full_speed;
      end
      KIND_LEFT: begin
        held_error = 8'(-int'(cfg_turn_limit));
        held_speed = cfg_turn_speed;
      end
      KIND_RIGHT: begin
        held_error = 8'(int'(cfg_turn_limit));
        held_speed = cfg_turn_speed;
      end
      default: ;
    endcase
    bias_now   = int'(held_error) - int'(cfg_err_offset);
    bias_delta = bias_now - int'(last_bias);
    drive      = longint'(cfg_prop_gain) * bias_now + longint'(cfg_deriv_gain) * bias_delta;
    last_bias  = 9'(bias_now);
    r.steer      = 26'(drive);
    r.speed      = held_speed;
    r.line_error = held_error;
    r.bias       = 9'(bias_now);
    return r;
  endfunction

  // One register write: a setup cycle, then an access cycle. The register takes
  // the value at the edge that closes the access cycle. An idle step with the select low
  // follows so that back-to-back writes never drive the select twice in one step.
  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TURN_LIMIT: cfg_turn_limit = value[6:0];
      REG_FULL_SPEED: cfg_full_speed = value[15:0];
      REG_TURN_SPEED: cfg_turn_speed = value[15:0];
      REG_PROP_GAIN:  cfg_prop_gain  = value[15:0];
      REG_DERIV_GAIN: cfg_deriv_gain = value[15:0];
      REG_ERR_OFFSET: cfg_err_offset = value[7:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Mostly back-to-back transfers, some short gaps and a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (sender_burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one sensor pattern and returns at the edge where it is transferred.
  // Valid is only lowered when a gap follows, so a held valid is never dropped
  // and raised again within one step.
  task automatic send_sensor(input logic [7:0] bits);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sensor_bits_i <= bits;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(predict_steering(bits));
  endtask

  // Stops offering input until every expected result has been taken, then lets
  // the pipeline settle so the block is idle for register writes.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_word16();
    case ($urandom_range(0, 5))
      0:       return 32'hFFFF_8000;
      1:       return 32'h0000_7FFF;
      2:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_turn_limit();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return 32'd127;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_offset();
    case ($urandom_range(0, 5))
      0:       return 32'hFFFF_FF80;
      1:       return 32'h0000_007F;
      2:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Most patterns are legal line shapes: tracking patterns picked at random or
  // sweeping smoothly across the array, and turn shapes. The rest is noise.
  function automatic logic [7:0] pick_sensor_pattern();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      sweep_pos = $urandom_range(0, 14);
      return TRACK_PATTERNS[sweep_pos];
    end
    if (roll < 60) begin
      if ($urandom_range(0, 1) == 0) begin
        if (sweep_pos != 0) sweep_pos--;
      end else begin
        if (sweep_pos != 14) sweep_pos++;
      end
      return TRACK_PATTERNS[sweep_pos];
    end
    if (roll < 68) return LEFT_TURNS[$urandom_range(0, 4)];
    if (roll < 76) return RIGHT_TURNS[$urandom_range(0, 4)];
    return 8'($urandom);
  endfunction

  task automatic randomize_settings();
    write_reg(REG_TURN_LIMIT, pick_turn_limit());
    write_reg(REG_FULL_SPEED, pick_word16());
    write_reg(REG_TURN_SPEED, pick_word16());
    write_reg(REG_PROP_GAIN,  pick_word16());
    write_reg(REG_DERIV_GAIN, pick_word16());
    write_reg(REG_ERR_OFFSET, pick_offset());
  endtask

  // With reset settings only the turn limit of 20 is visible, on line_error and bias.
  // A blank sensor row must then hold that error.
  task automatic test_reset_values();
    send_sensor(8'h3F);
    send_sensor(8'h00);
  endtask

  // Walks the whole decode table with nonzero gains, distinct speeds and an offset.
  task automatic test_decode_table();
    drain_results();
    write_reg(REG_TURN_LIMIT, 32'd127);
    write_reg(REG_FULL_SPEED, 32'h0000_7FFF);
    write_reg(REG_TURN_SPEED, 32'hFFFF_8000);
    write_reg(REG_PROP_GAIN,  32'h0000_0180);
    write_reg(REG_DERIV_GAIN, 32'hFFFF_FF40);
    write_reg(REG_ERR_OFFSET, 32'hFFFF_FFFD);
    foreach (TRACK_PATTERNS[i]) send_sensor(TRACK_PATTERNS[i]);
    foreach (LEFT_TURNS[i]) send_sensor(LEFT_TURNS[i]);
    foreach (RIGHT_TURNS[i]) send_sensor(RIGHT_TURNS[i]);
  endtask

  // Drives the steering sum to its largest magnitudes: an offset of -128 pushes
  // the bias to 255, then an offset of 127 swings it to -254, the widest step
  // the derivative term can see. Both gain signs are used at full scale.
  task automatic test_extreme_drive();
    drain_results();
    write_reg(REG_TURN_LIMIT, 32'd127);
    write_reg(REG_PROP_GAIN,  32'hFFFF_8000);
    write_reg(REG_DERIV_GAIN, 32'hFFFF_8000);
    write_reg(REG_ERR_OFFSET, 32'hFFFF_FF80);
    send_sensor(8'h07);
    drain_results();
    write_reg(REG_ERR_OFFSET, 32'h0000_007F);
    send_sensor(8'h70);
    drain_results();
    write_reg(REG_PROP_GAIN,  32'h0000_7FFF);
    write_reg(REG_DERIV_GAIN, 32'h0000_7FFF);
    send_sensor(8'h1F);
    send_sensor(8'h00);
  endtask

  // Several phases, each with fresh register settings. Midway through each phase
  // the sender holds off until the output side has taken every result.
  task automatic test_random_stream();
    logic [7:0] bits;
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      randomize_settings();
      sender_burst = 1'b0;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PAUSE_AT_ITEM) drain_results();
        if ($urandom_range(0, 79) == 0) sender_burst = !sender_burst;
        bits = pick_sensor_pattern();
        send_sensor(bits);
      end
    end
  endtask

  // Output backpressure: runs of one style each, from always ready through
  // random stalls to occasional long stalls.
  ready_style_e ready_style      = READY_ALWAYS;
  int unsigned  ready_run_left   = 0;
  int unsigned  ready_stall_left = 0;

  always @(posedge clk_i) begin
    if (ready_run_left == 0) begin
      ready_style    = ready_style_e'($urandom_range(0, 3));
      ready_run_left = $urandom_range(16, 160);
    end
    ready_run_left--;
    if (ready_stall_left != 0) begin
      ready_stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (ready_style)
        READY_ALWAYS: out_ready_i <= 1'b1;
        READY_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
        READY_HALF:   out_ready_i <= ($urandom_range(0, 1) != 0);
        default: begin
          if ($urandom_range(0, 31) == 0) ready_stall_left = $urandom_range(8, 40);
          out_ready_i <= (ready_stall_left == 0);
        end
      endcase
    end
  end

  // Each result transfer is checked against the oldest expectation, field by field.
  always @(posedge clk_i) begin : check_results
    steer_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result transfer with no expected result waiting", $time);
      end else begin
        want = pending_results.pop_front();
        if (steer_o !== want.steer) begin
          mismatch_count++;
          $display("%0t: steer expected %0d, got %0d", $time, want.steer, steer_o);
        end
        if (speed_o !== want.speed) begin
          mismatch_count++;
          $display("%0t: speed expected %0d, got %0d", $time, want.speed, speed_o);
        end
        if (line_error_o !== want.line_error) begin
          mismatch_count++;
          $display("%0t: line_error expected %0d, got %0d", $time, want.line_error,
                   line_error_o);
        end
        if (bias_o !== want.bias) begin
          mismatch_count++;
          $display("%0t: bias expected %0d, got %0d", $time, want.bias, bias_o);
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_decode_table();
    test_extreme_drive();
    test_random_stream();
    drain_results();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
